>>> rtl/trj_pkg.sv
// -----------------------------------------------------------------------------
// trj_pkg: shared types and constants for the trajectory sample interpolator
// Holds the word and config structs, register indexes and sequencer states.
// -----------------------------------------------------------------------------
package trj_pkg;

   localparam int VAL_W       = 32;
   localparam int NUM_VAL     = 6;
   localparam int TIME_W      = 24;
   localparam int QTIME_W     = 25;
   localparam int FRAC_W      = 16;
   localparam int QUO_W       = TIME_W + FRAC_W;
   localparam int STEP_W      = $clog2(QUO_W);
   localparam int SLOT_W      = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_W     = 6;
   localparam int STAMP_W     = 32;
   localparam int VALIDITY_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int COMP_W      = 3;
   localparam int PROD_W      = VAL_W + 1 + FRAC_W + 1;

   localparam logic [TIME_W-1:0]     INTERVAL_RESET = 24'd6554;
   localparam logic [VALIDITY_W-1:0] VALIDITY_RESET = 16'd500;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRAJ_VALID      = 3'd0,
      CSR_SAMPLE_COUNT    = 3'd1,
      CSR_SAMPLE_INTERVAL = 3'd2,
      CSR_STAMP_MS        = 3'd3,
      CSR_VALIDITY_MS     = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEL,
      ST_RDA,
      ST_RDB,
      ST_MUL,
      ST_ADD,
      ST_RDL,
      ST_LAST,
      ST_DONE
   } state_type;

   typedef logic [NUM_VAL-1:0][VAL_W-1:0] sample_type;

   typedef struct packed {
      logic                  traj_valid;
      logic [COUNT_W-1:0]    sample_count;
      logic [TIME_W-1:0]     sample_interval;
      logic [STAMP_W-1:0]    stamp_ms;
      logic [VALIDITY_W-1:0] validity_ms;
   } cfg_type;

   typedef struct packed {
      logic              is_query;
      logic [SLOT_W-1:0] slot;
      logic              slot_ok;
      logic              usable;
      logic              use_first;
      logic              fresh;
      logic [TIME_W-1:0] time_val;
      sample_type        sample;
   } item_type;

endpackage

>>> rtl/trj_if.sv
// -----------------------------------------------------------------------------
// trj_if: channel interfaces for request, response and register write words
// Each carries valid, ready and the payload with source and sink modports.
// -----------------------------------------------------------------------------
interface trj_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [4:0]  entry_index;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [24:0] query_time;
   logic [31:0] now_ms;
   modport source (output valid, req_type, entry_index, pos_x, pos_y, pos_z,
                   vel_x, vel_y, vel_z, query_time, now_ms, input ready);
   modport sink (input valid, req_type, entry_index, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, query_time, now_ms, output ready);
endinterface

interface trj_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [31:0] out_vel_x;
   logic signed [31:0] out_vel_y;
   logic signed [31:0] out_vel_z;
   logic        eval_ok;
   logic        is_fresh;
   modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                   out_vel_y, out_vel_z, eval_ok, is_fresh, input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_vel_x,
                 out_vel_y, out_vel_z, eval_ok, is_fresh, output ready);
endinterface

interface trj_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/trj_front.sv
// -----------------------------------------------------------------------------
// trj_front: request intake and classification
// Tags each word as load or query, settles usability, first-sample and
// freshness, and holds it in a two-entry queue for the back end.
// -----------------------------------------------------------------------------
module trj_front #(
   parameter int MAX_POINTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  trj_pkg::cfg_type  cfg,
   trj_req_if.sink           req_bus,
   input  logic              pop,
   output logic              item_valid,
   output trj_pkg::item_type item
);

   trj_pkg::item_type cls;
   trj_pkg::item_type q_ff [trj_pkg::QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   logic [trj_pkg::STAMP_W-1:0] age;

   // classify the incoming word
   always_comb begin
      cls.is_query  = (req_bus.req_type == trj_pkg::REQ_QUERY);
      cls.slot      = req_bus.entry_index;
      cls.slot_ok   = 32'(req_bus.entry_index) < 32'(MAX_POINTS);
      cls.usable    = cfg.traj_valid && (cfg.sample_count != '0)
                      && (32'(cfg.sample_count) <= 32'(MAX_POINTS))
                      && (cfg.sample_interval != '0);
      cls.use_first = (cfg.sample_count == 6'd1) || req_bus.query_time[24]
                      || (req_bus.query_time == '0);
      age           = (req_bus.now_ms >= cfg.stamp_ms) ?
                      (req_bus.now_ms - cfg.stamp_ms) : '0;
      cls.fresh     = cls.usable && (age <= 32'(cfg.validity_ms));
      cls.time_val  = req_bus.query_time[trj_pkg::TIME_W-1:0];
      cls.sample    = {req_bus.vel_z, req_bus.vel_y, req_bus.vel_x,
                       req_bus.pos_z, req_bus.pos_y, req_bus.pos_x};
   end

   // queue control
   always_comb begin
      req_bus.ready = (cnt_ff != 2'(trj_pkg::QUEUE_DEPTH));
      push          = req_bus.valid && req_bus.ready;
      item_valid    = (cnt_ff != '0);
      item          = q_ff[rd_ptr_ff];
      wr_ptr_in     = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in        = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // hold queued words
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> rtl/trj_back.sv
// -----------------------------------------------------------------------------
// trj_back: sample stores and query execution
// Writes loaded samples, divides time by interval one bit a cycle, reads the
// bracketing samples and blends the six components through one multiplier.
// -----------------------------------------------------------------------------
module trj_back #(
   parameter int MAX_POINTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  trj_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  trj_pkg::item_type item,
   output logic              pop,
   trj_rsp_if.source         rsp_bus
);

   localparam int IW = $clog2(MAX_POINTS);

   trj_pkg::state_type state_ff, state_in;

   // sample store with per-entry valid bits
   trj_pkg::sample_type store_ff [MAX_POINTS];
   logic [MAX_POINTS-1:0] vld_ff, vld_in;
   logic                  wr_en;
   logic [IW-1:0]         addr_ff, addr_in;
   trj_pkg::sample_type   rd_ff;
   logic                  rdv_ff;
   trj_pkg::sample_type   rd_val;

   // divider
   logic [trj_pkg::QUO_W-1:0]  num_ff, num_in;
   logic [trj_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [trj_pkg::STEP_W-1:0] step_ff, step_in;
   logic [trj_pkg::TIME_W+1:0] trial;

   // blend datapath
   trj_pkg::sample_type        a_ff, a_in;
   trj_pkg::sample_type        res_ff, res_in;
   logic                       ok_ff, ok_in;
   logic                       fresh_ff, fresh_in;
   logic [trj_pkg::COMP_W-1:0] k_ff, k_in;
   logic signed [trj_pkg::PROD_W-1:0] p_ff, p_in;
   logic signed [trj_pkg::VAL_W:0]    diff;
   logic signed [trj_pkg::FRAC_W:0]   frac;
   logic signed [trj_pkg::PROD_W-1:0] q_full;
   logic signed [trj_pkg::VAL_W+2:0]  sum;
   logic [trj_pkg::VAL_W-1:0]         sat;
   logic [trj_pkg::VAL_W-1:0]         a_k;
   logic [trj_pkg::TIME_W-1:0]        idx;
   logic [trj_pkg::TIME_W-1:0]        last_idx;

   // output register
   trj_pkg::sample_type out_val_ff, out_val_in;
   logic out_ok_ff, out_ok_in, out_fresh_ff, out_fresh_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic load_out;

   // datapath helpers
   always_comb begin
      rd_val   = rdv_ff ? rd_ff : '0;
      trial    = {1'b0, rem_ff, num_ff[trj_pkg::QUO_W-1]}
                 - {2'b00, cfg.sample_interval};
      idx      = num_ff[trj_pkg::QUO_W-1:trj_pkg::FRAC_W];
      last_idx = trj_pkg::TIME_W'(cfg.sample_count) - 1'b1;
      a_k      = a_ff[k_ff];
      diff     = {rd_val[k_ff][trj_pkg::VAL_W-1], rd_val[k_ff]}
                 - {a_k[trj_pkg::VAL_W-1], a_k};
      frac     = {1'b0, num_ff[trj_pkg::FRAC_W-1:0]};
      q_full   = (p_ff + trj_pkg::PROD_W'(32768)) >>> trj_pkg::FRAC_W;
      sum      = {{3{a_k[trj_pkg::VAL_W-1]}}, a_k}
                 + {q_full[trj_pkg::VAL_W+1], q_full[trj_pkg::VAL_W+1:0]};
      if (sum[trj_pkg::VAL_W+2:trj_pkg::VAL_W-1] == '0
          || sum[trj_pkg::VAL_W+2:trj_pkg::VAL_W-1] == '1) begin
         sat = sum[trj_pkg::VAL_W-1:0];
      end else if (sum[trj_pkg::VAL_W+2]) begin
         sat = {1'b1, {(trj_pkg::VAL_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(trj_pkg::VAL_W-1){1'b1}}};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      wr_en    = 1'b0;
      vld_in   = vld_ff;
      addr_in  = addr_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      res_in   = res_ff;
      ok_in    = ok_ff;
      fresh_in = fresh_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      load_out = 1'b0;
      case (state_ff)
         trj_pkg::ST_IDLE: begin
            if (item_valid) begin
               pop = 1'b1;
               if (!item.is_query) begin
                  if (item.slot_ok) begin
                     wr_en = 1'b1;
                     vld_in[IW'(item.slot)] = 1'b1;
                  end
               end else begin
                  fresh_in = item.fresh;
                  ok_in    = item.usable;
                  if (!item.usable) begin
                     res_in   = '0;
                     state_in = trj_pkg::ST_DONE;
                  end else if (item.use_first) begin
                     addr_in  = '0;
                     state_in = trj_pkg::ST_RDL;
                  end else begin
                     num_in   = {item.time_val, {trj_pkg::FRAC_W{1'b0}}};
                     rem_in   = '0;
                     step_in  = '0;
                     state_in = trj_pkg::ST_DIV;
                  end
               end
            end
         end
         trj_pkg::ST_DIV: begin
            // one restoring step per cycle
            if (trial[trj_pkg::TIME_W+1]) begin
               rem_in = {rem_ff[trj_pkg::TIME_W-2:0], num_ff[trj_pkg::QUO_W-1]};
            end else begin
               rem_in = trial[trj_pkg::TIME_W-1:0];
            end
            num_in  = {num_ff[trj_pkg::QUO_W-2:0], ~trial[trj_pkg::TIME_W+1]};
            step_in = step_ff + 1'b1;
            if (step_ff == trj_pkg::STEP_W'(trj_pkg::QUO_W - 1)) begin
               state_in = trj_pkg::ST_SEL;
            end
         end
         trj_pkg::ST_SEL: begin
            if (idx >= last_idx) begin
               addr_in  = IW'(last_idx);
               state_in = trj_pkg::ST_RDL;
            end else begin
               addr_in  = IW'(idx);
               state_in = trj_pkg::ST_RDA;
            end
         end
         trj_pkg::ST_RDA: begin
            addr_in  = IW'(addr_ff + 1'b1);
            state_in = trj_pkg::ST_RDB;
         end
         trj_pkg::ST_RDB: begin
            a_in     = rd_val;
            k_in     = '0;
            state_in = trj_pkg::ST_MUL;
         end
         trj_pkg::ST_MUL: begin
            p_in     = diff * frac;
            state_in = trj_pkg::ST_ADD;
         end
         trj_pkg::ST_ADD: begin
            res_in[k_ff] = sat;
            k_in         = k_ff + 1'b1;
            if (k_ff == trj_pkg::COMP_W'(trj_pkg::NUM_VAL - 1)) begin
               state_in = trj_pkg::ST_DONE;
            end else begin
               state_in = trj_pkg::ST_MUL;
            end
         end
         trj_pkg::ST_RDL: begin
            state_in = trj_pkg::ST_LAST;
         end
         trj_pkg::ST_LAST: begin
            res_in   = rd_val;
            state_in = trj_pkg::ST_DONE;
         end
         trj_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_out = 1'b1;
               state_in = trj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trj_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = (rsp_valid_ff && !rsp_bus.ready) || load_out;
      out_val_in   = load_out ? res_ff : out_val_ff;
      out_ok_in    = load_out ? ok_ff : out_ok_ff;
      out_fresh_in = load_out ? fresh_ff : out_fresh_ff;
      rsp_bus.valid     = rsp_valid_ff;
      rsp_bus.out_pos_x = out_val_ff[0];
      rsp_bus.out_pos_y = out_val_ff[1];
      rsp_bus.out_pos_z = out_val_ff[2];
      rsp_bus.out_vel_x = out_val_ff[3];
      rsp_bus.out_vel_y = out_val_ff[4];
      rsp_bus.out_vel_z = out_val_ff[5];
      rsp_bus.eval_ok   = out_ok_ff;
      rsp_bus.is_fresh  = out_fresh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trj_pkg::ST_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      a_ff         <= a_in;
      res_ff       <= res_in;
      ok_ff        <= ok_in;
      fresh_ff     <= fresh_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      out_val_ff   <= out_val_in;
      out_ok_ff    <= out_ok_in;
      out_fresh_ff <= out_fresh_in;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[IW'(item.slot)] <= item.sample;
      end
      rd_ff  <= store_ff[addr_ff];
      rdv_ff <= vld_ff[addr_ff];
   end

endmodule

>>> rtl/trajectory_sample_interpolator_top.sv
// -----------------------------------------------------------------------------
// Query paths: an unusable query goes straight to the done state, the
// first-sample path reads sample 0, the last-sample path divides and then
// reads the last sample, and a blend divides, selects and reads two samples
// and runs the six components in turn through the shared multiplier.
// The back end takes one word at a time, a load word or a query.
// Synchronous reset clears the queue, sample valid bits, registers to defaults.
// trajectory_sample_interpolator_top: register block, front end and back end
// -----------------------------------------------------------------------------
module trajectory_sample_interpolator_top #(
   parameter int MAX_POINTS = 32
) (
   input  logic      clock,
   input  logic      reset,
   trj_req_if.sink   req_bus,
   trj_rsp_if.source rsp_bus,
   trj_csr_if.sink   csr_bus
);

   trj_pkg::cfg_type  cfg_ff, cfg_in;
   trj_pkg::item_type item;
   logic              item_valid;
   logic              pop;
   logic              csr_wr;

   // register writes
   always_comb begin
      csr_bus.ready = 1'b1;
      csr_wr        = csr_bus.valid && csr_bus.ready;
      cfg_in        = cfg_ff;
      if (csr_wr) begin
         case (trj_pkg::csr_index_type'(csr_bus.index))
            trj_pkg::CSR_TRAJ_VALID:      cfg_in.traj_valid = csr_bus.data[0];
            trj_pkg::CSR_SAMPLE_COUNT:
               cfg_in.sample_count = csr_bus.data[trj_pkg::COUNT_W-1:0];
            trj_pkg::CSR_SAMPLE_INTERVAL:
               cfg_in.sample_interval = csr_bus.data[trj_pkg::TIME_W-1:0];
            trj_pkg::CSR_STAMP_MS:        cfg_in.stamp_ms = csr_bus.data;
            trj_pkg::CSR_VALIDITY_MS:
               cfg_in.validity_ms = csr_bus.data[trj_pkg::VALIDITY_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.traj_valid      <= 1'b0;
         cfg_ff.sample_count    <= '0;
         cfg_ff.sample_interval <= trj_pkg::INTERVAL_RESET;
         cfg_ff.stamp_ms        <= '0;
         cfg_ff.validity_ms     <= trj_pkg::VALIDITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trj_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   trj_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule
